### sv/upkf_pkg.sv
// ---------------------------------------------------------------------------
// upkf_pkg
// Shared constants, types and the set hash for the port-knock filter.
// ---------------------------------------------------------------------------
package upkf_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int TABLE_WAYS  = 4;
   localparam int KEY_BYTES   = 6;

   localparam logic [15:0] KNOCK_PORT_RESET    = 16'd12345;
   localparam logic [47:0] SECRET_KEY_RESET    = 48'h736563726574;
   localparam logic [7:0]  FAILURE_LIMIT_RESET = 8'd3;

   localparam logic [1:0] CSR_KNOCK_PORT    = 2'd0;
   localparam logic [1:0] CSR_SECRET_KEY    = 2'd1;
   localparam logic [1:0] CSR_FAILURE_LIMIT = 2'd2;

   localparam logic [1:0] EVT_NONE   = 2'd0;
   localparam logic [1:0] EVT_ACCEPT = 2'd1;
   localparam logic [1:0] EVT_FAIL   = 2'd2;

   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] PAYLOAD_START = 16'd42;
   localparam logic [15:0] MIN_SRC_LEN   = 16'd34;

   // controller -> datapath commands
   typedef struct packed {
      logic clear_start;  // begin clearing sweep
      logic clear_step;   // write entry at clear index
      logic frame_close;  // latch frame summary
      logic lookup;       // issue RAM reads for the next way
      logic way_check;    // inspect returned way data
      logic decide;       // compute verdict and write plan
      logic commit;       // perform table write, load result
   } ctl_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic clear_done;
      logic last_way;
   } dp_status_type;

   function automatic logic [31:0] fold_hash(input logic [31:0] a);
      logic [31:0] h;
      h = a ^ (a >> 16);
      h = h ^ (h >> 8);
      return h;
   endfunction

endpackage

### sv/upkf_ram.sv
// ---------------------------------------------------------------------------
// upkf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module upkf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/upkf_ctrl.sv
// ---------------------------------------------------------------------------
// upkf_ctrl
// Sequencer: clearing sweep, byte intake, per-way table walk, commit, output.
// ---------------------------------------------------------------------------
module upkf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  upkf_pkg::dp_status_type status,
   output upkf_pkg::ctl_cmd_type  cmd,
   output logic                   byte_take
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       started_ff;

   assign rsp_valid = rsp_valid_ff;
   // a result may wait in the output register while the next frame streams in
   assign req_ready = (state_ff == ST_IDLE) && !(req_frame_end && rsp_valid_ff && !rsp_ready);
   assign byte_take = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_start = !started_ff;
            cmd.clear_step  = started_ff;
            if (started_ff && status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (byte_take && req_frame_end) begin
               cmd.frame_close = 1'b1;
               state_in        = ST_READ;
            end
         end
         ST_READ: begin
            cmd.lookup = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.way_check = 1'b1;
            state_in      = status.last_way ? ST_DECIDE : ST_READ;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= 1'b1;
      end
   end

endmodule

### sv/upkf_datapath.sv
// ---------------------------------------------------------------------------
// upkf_datapath
// Header capture, payload shift, two set-associative tables and verdict.
// ---------------------------------------------------------------------------
module upkf_datapath #(
   parameter int TABLE_DEPTH = upkf_pkg::TABLE_DEPTH,
   parameter int TABLE_WAYS  = upkf_pkg::TABLE_WAYS,
   parameter int KEY_BYTES   = upkf_pkg::KEY_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  upkf_pkg::ctl_cmd_type  cmd,
   output upkf_pkg::dp_status_type status,
   input  logic                   byte_take,
   input  logic [7:0]             frame_byte,
   input  logic                   rsp_load,
   input  logic [15:0]            knock_port,
   input  logic [47:0]            secret_key,
   input  logic [7:0]             failure_limit,
   output logic                   rsp_verdict,
   output logic [1:0]             rsp_knock_event,
   output logic [31:0]            rsp_source_address,
   output logic                   rsp_insert_refused
);

   localparam int SETS   = TABLE_DEPTH / TABLE_WAYS;
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W  = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int KEY_W  = 8 * KEY_BYTES;
   localparam int FW     = 41;
   localparam int AW     = 33;
   localparam logic [15:0] KNOCK_LEN = upkf_pkg::PAYLOAD_START + 16'(KEY_BYTES);

   // ---- byte intake ----
   logic [15:0] pos_ff;
   logic [31:0] src_ff;
   logic [7:0]  proto_ff;
   logic [15:0] port_ff;
   logic [63:0] pay_ff;

   logic [31:0] src_next;
   logic [7:0]  proto_next;
   logic [15:0] port_next;
   logic [63:0] pay_next;

   always_comb begin
      src_next   = src_ff;
      proto_next = proto_ff;
      port_next  = port_ff;
      pay_next   = pay_ff;
      if (pos_ff == 16'd23) proto_next = frame_byte;
      if (pos_ff >= 16'd26 && pos_ff <= 16'd29) src_next = {src_ff[23:0], frame_byte};
      if (pos_ff == 16'd36 || pos_ff == 16'd37) port_next = {port_ff[7:0], frame_byte};
      if (pos_ff >= upkf_pkg::PAYLOAD_START) pay_next = {pay_ff[55:0], frame_byte};
   end

   // ---- latched frame summary ----
   logic [31:0]      fsrc_ff;
   logic             has_src_ff;
   logic             knock_ff;
   logic             match_ff;
   logic [SET_W-1:0] set_ff;
   logic [WAY_W-1:0] way_ff;

   logic [63:0] key_ext;
   assign key_ext = 64'(secret_key);

   always_ff @(posedge clock) begin
      if (reset || cmd.frame_close) begin
         pos_ff   <= '0;
         src_ff   <= '0;
         proto_ff <= '0;
         port_ff  <= '0;
         pay_ff   <= '0;
      end else if (byte_take) begin
         if (pos_ff != 16'hFFFF) pos_ff <= pos_ff + 16'd1;
         src_ff   <= src_next;
         proto_ff <= proto_next;
         port_ff  <= port_next;
         pay_ff   <= pay_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_close) begin
         has_src_ff <= (pos_ff >= upkf_pkg::MIN_SRC_LEN - 16'd1);
         fsrc_ff    <= src_next;
         knock_ff   <= (pos_ff + 16'd1 == KNOCK_LEN) && (proto_next == upkf_pkg::PROTO_UDP)
                       && (port_next == knock_port);
         match_ff   <= (pay_next[KEY_W-1:0] == key_ext[KEY_W-1:0]);
         set_ff     <= SET_W'(upkf_pkg::fold_hash(src_next) % 32'(SETS));
      end
   end

   // ---- tables ----
   logic              f_we, a_we;
   logic [ADDR_W-1:0] f_wa, a_wa, rd_a;
   logic [FW-1:0]     f_wd, f_rd;
   logic [AW-1:0]     a_wd, a_rd;

   upkf_ram #(.WIDTH(FW), .DEPTH(TABLE_DEPTH)) u_fail (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(rd_a), .rd_data(f_rd));
   upkf_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_allow (
      .clock(clock), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd),
      .rd_addr(rd_a), .rd_data(a_rd));

   logic [ADDR_W-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (cmd.clear_start) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + ADDR_W'(1);
   end
   assign status.clear_done = (clr_ff == ADDR_W'(TABLE_DEPTH - 1));

   function automatic logic [ADDR_W-1:0] mk_addr(input logic [SET_W-1:0] s,
                                                 input logic [WAY_W-1:0] w);
      return ADDR_W'(32'(s) * 32'(TABLE_WAYS) + 32'(w));
   endfunction

   assign rd_a = mk_addr(set_ff, way_ff);
   assign status.last_way = (way_ff == WAY_W'(TABLE_WAYS - 1));

   // walk state
   logic             f_hit_ff, f_free_ok_ff, a_found_ff, a_free_ok_ff;
   logic [WAY_W-1:0] f_hit_way_ff, f_free_ff, a_free_ff;
   logic [7:0]       f_cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.frame_close) begin
         way_ff       <= '0;
         f_hit_ff     <= 1'b0;
         f_free_ok_ff <= 1'b0;
         a_found_ff   <= 1'b0;
         a_free_ok_ff <= 1'b0;
      end else if (cmd.way_check) begin
         if (!status.last_way) way_ff <= way_ff + WAY_W'(1);
         if (f_rd[40] && f_rd[39:8] == fsrc_ff && !f_hit_ff) begin
            f_hit_ff     <= 1'b1;
            f_hit_way_ff <= way_ff;
            f_cnt_ff     <= f_rd[7:0];
         end
         if (!f_rd[40] && !f_free_ok_ff) begin
            f_free_ok_ff <= 1'b1;
            f_free_ff    <= way_ff;
         end
         if (a_rd[32] && a_rd[31:0] == fsrc_ff) a_found_ff <= 1'b1;
         if (!a_rd[32] && !a_free_ok_ff) begin
            a_free_ok_ff <= 1'b1;
            a_free_ff    <= way_ff;
         end
      end
   end

   // decision
   logic        verd_ff, refused_ff, fw_ff, aw_ff;
   logic [1:0]  evt_ff;
   logic [ADDR_W-1:0] fwa_ff, awa_ff;
   logic [FW-1:0]     fwd_ff;

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         verd_ff    <= 1'b0;
         evt_ff     <= upkf_pkg::EVT_NONE;
         refused_ff <= 1'b0;
         fw_ff      <= 1'b0;
         aw_ff      <= 1'b0;
         fwa_ff     <= mk_addr(set_ff, f_hit_ff ? f_hit_way_ff : f_free_ff);
         awa_ff     <= mk_addr(set_ff, a_free_ff);
         fwd_ff     <= {1'b1, fsrc_ff, f_hit_ff ? f_cnt_ff + 8'(f_cnt_ff != 8'hFF) : 8'd1};
         if (has_src_ff) begin
            if (f_hit_ff && f_cnt_ff > failure_limit) begin
               verd_ff <= 1'b1;
            end else if (knock_ff) begin
               if (match_ff) begin
                  evt_ff <= upkf_pkg::EVT_ACCEPT;
                  if (!a_found_ff) begin
                     aw_ff      <= a_free_ok_ff;
                     refused_ff <= !a_free_ok_ff;
                  end
               end else begin
                  evt_ff <= upkf_pkg::EVT_FAIL;
                  fw_ff      <= f_hit_ff || f_free_ok_ff;
                  refused_ff <= !(f_hit_ff || f_free_ok_ff);
               end
            end
         end
      end
   end

   always_comb begin
      f_we = cmd.clear_step || (cmd.commit && fw_ff);
      a_we = cmd.clear_step || (cmd.commit && aw_ff);
      f_wa = cmd.clear_step ? clr_ff : fwa_ff;
      a_wa = cmd.clear_step ? clr_ff : awa_ff;
      f_wd = cmd.clear_step ? '0 : fwd_ff;
      a_wd = cmd.clear_step ? '0 : {1'b1, fsrc_ff};
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_verdict        <= verd_ff;
         rsp_knock_event    <= evt_ff;
         rsp_source_address <= has_src_ff ? fsrc_ff : 32'd0;
         rsp_insert_refused <= refused_ff;
      end
   end

endmodule

### sv/udp_port_knock_filter.sv
// ---------------------------------------------------------------------------
// udp_port_knock_filter
// Port-knocking filter: one verdict per Ethernet frame.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel carries one frame byte per transaction, req_frame_end on the
//   final byte. The closing byte starts a table walk: a RAM read step and a
//   check step for each way, then decide and commit; no byte of the next
//   frame is taken until the walk is done. The rsp_ channel returns one
//   verdict transaction per frame, valid once the commit step has loaded the
//   result. The walk is bounded by the single read port of each table RAM.
//   csr_ writes registers 0 knock_port, 1 secret_key, 2 failure_limit; it is
//   always ready.
//   Reset: both tables are swept clear, one entry per cycle, during which
//   req_ready is low.
//   When rsp_ready is low, the result holds in the output register; bytes
//   of the next frame are still taken, up to its closing byte.
// ---------------------------------------------------------------------------
module udp_port_knock_filter #(
   parameter int TABLE_DEPTH = upkf_pkg::TABLE_DEPTH,
   parameter int TABLE_WAYS  = upkf_pkg::TABLE_WAYS,
   parameter int KEY_BYTES   = upkf_pkg::KEY_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_verdict,
   output logic [1:0]  rsp_knock_event,
   output logic [31:0] rsp_source_address,
   output logic        rsp_insert_refused,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [15:0] knock_port_ff;
   logic [47:0] secret_key_ff;
   logic [7:0]  failure_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         knock_port_ff    <= upkf_pkg::KNOCK_PORT_RESET;
         secret_key_ff    <= upkf_pkg::SECRET_KEY_RESET;
         failure_limit_ff <= upkf_pkg::FAILURE_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            upkf_pkg::CSR_KNOCK_PORT:    knock_port_ff    <= csr_data[15:0];
            upkf_pkg::CSR_SECRET_KEY:    secret_key_ff    <= csr_data;
            upkf_pkg::CSR_FAILURE_LIMIT: failure_limit_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   upkf_pkg::ctl_cmd_type   cmd;
   upkf_pkg::dp_status_type status;
   logic                    byte_take;

   upkf_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd), .byte_take(byte_take));

   upkf_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH), .TABLE_WAYS(TABLE_WAYS), .KEY_BYTES(KEY_BYTES)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .byte_take(byte_take), .frame_byte(req_frame_byte), .rsp_load(cmd.commit),
      .knock_port(knock_port_ff), .secret_key(secret_key_ff),
      .failure_limit(failure_limit_ff),
      .rsp_verdict(rsp_verdict), .rsp_knock_event(rsp_knock_event),
      .rsp_source_address(rsp_source_address),
      .rsp_insert_refused(rsp_insert_refused));

   // a dropped frame never reports a knock
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict |-> rsp_knock_event == upkf_pkg::EVT_NONE)
      else $error("dropped frame reports knock");

   // refusal only follows a knock attempt
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_insert_refused |-> rsp_knock_event != upkf_pkg::EVT_NONE)
      else $error("refusal without knock");

   // held result stays stable under backpressure
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source_address))
      else $error("result changed while stalled");

endmodule
